// ===== src/csst_pkg.sv =====
// Shared types and constants for the client session sequence tracker.
// Used by the slot cell, the top level and the port checker; no dependencies.
`default_nettype none
package csst_pkg;

  localparam int unsigned MASK_W = 4;
  localparam int unsigned CNT_NUM = 7;
  localparam logic [31:0] SEQ_HALF = 32'h8000_0000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [1:0] DS_OK = 2'd0;
  localparam logic [1:0] DS_CRC = 2'd1;
  localparam logic [1:0] DS_DECODE = 2'd2;
  localparam logic [1:0] DS_SIZE = 2'd3;

  localparam int unsigned CNT_RECEIVED = 0;
  localparam int unsigned CNT_LOST = 1;
  localparam int unsigned CNT_INVALID = 2;
  localparam int unsigned CNT_CRC = 3;
  localparam int unsigned CNT_PROTOCOL = 4;
  localparam int unsigned CNT_FOREIGN = 5;
  localparam int unsigned CNT_OOO = 6;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_INVALID_SIZE = 3'd1,
    ST_CRC = 3'd2,
    ST_DECODE = 3'd3,
    ST_BAD_SLOT = 3'd4,
    ST_FOREIGN = 3'd5,
    ST_OUT_OF_ORDER = 3'd6,
    ST_TICK = 3'd7
  } status_t;

  typedef struct packed {
    logic vld;
    logic pkt;
    logic tick;
    logic [7:0] slot;
    logic [31:0] now;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] sess;
    logic [31:0] seq;
    status_t status;
    logic bound;
    logic [31:0] gap;
    logic [MASK_W-1:0] mask;
  } csst_tok_t;

endpackage
`default_nettype wire

// ===== src/client_session_sequence_tracker.sv =====
// Path from input acceptance to out_valid: entry register, the register of each slot cell
// in the chain, counter stage, output register.
// One word in flight at a time: in_ready stays low from acceptance until the word is loaded
// into the output register; each word walks the whole cell chain so that every slot sees it once.
// Reset (rst_n low, synchronous) disconnects all slots, zeroes the counters and
// sets timeout_ms to 1000. Depends on csst_pkg and csst_cell.
`default_nettype none
module client_session_sequence_tracker #(
  parameter int SLOT_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [1:0]  in_decode_status,
  input  wire logic [7:0]  in_slot_index,
  input  wire logic [31:0] in_source_ip,
  input  wire logic [15:0] in_source_port,
  input  wire logic [31:0] in_session_id,
  input  wire logic [31:0] in_sequence_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot_out,
  output logic             out_newly_bound,
  output logic [31:0]      out_lost_in_gap,
  output logic [3:0]       out_dropped_mask,
  output logic [31:0]      out_received_total,
  output logic [31:0]      out_lost_total,
  output logic [31:0]      out_invalid_total,
  output logic [31:0]      out_crc_error_total,
  output logic [31:0]      out_protocol_error_total,
  output logic [31:0]      out_foreign_total,
  output logic [31:0]      out_out_of_order_total
);
  import csst_pkg::*;

  logic [15:0] timeout_r;
  logic        busy_r, busy_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic        out_v_r, out_v_nxt;
  csst_tok_t   tok0_r, tok0_nxt;
  csst_tok_t   tok_w [SLOT_COUNT+1];
  csst_tok_t   exit_tok;
  csst_tok_t   pend_r;
  csst_tok_t   out_r;
  logic [31:0] cnt_r [CNT_NUM];
  logic [31:0] cnt_nxt [CNT_NUM];
  logic [31:0] pend_cnt_r [CNT_NUM];
  logic [31:0] out_cnt_r [CNT_NUM];
  logic        in_acc;
  logic        out_load;
  logic        bad_slot;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;
  assign out_load = pend_v_r && (!out_v_r || out_ready);
  assign bad_slot = in_slot_index >= 8'(SLOT_COUNT);

  always_comb begin
    tok0_nxt       = '0;
    tok0_nxt.vld   = in_acc;
    tok0_nxt.tick  = in_mode;
    tok0_nxt.pkt   = !in_mode && (in_decode_status == DS_OK) && !bad_slot;
    tok0_nxt.slot  = in_mode ? 8'd0 : in_slot_index;
    tok0_nxt.now   = in_now_ms;
    tok0_nxt.ip    = in_source_ip;
    tok0_nxt.port  = in_source_port;
    tok0_nxt.sess  = in_session_id;
    tok0_nxt.seq   = in_sequence_req;
    if (in_mode) begin
      tok0_nxt.status = ST_TICK;
    end else begin
      unique case (in_decode_status)
        DS_CRC:    tok0_nxt.status = ST_CRC;
        DS_DECODE: tok0_nxt.status = ST_DECODE;
        DS_SIZE:   tok0_nxt.status = ST_INVALID_SIZE;
        default:   tok0_nxt.status = bad_slot ? ST_BAD_SLOT : ST_ACCEPTED;
      endcase
    end
  end

  assign tok_w[0] = tok0_r;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    csst_cell #(
      .INDEX(g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .timeout_ms(timeout_r),
      .tok_i     (tok_w[g]),
      .tok_o     (tok_w[g+1])
    );
  end

  assign exit_tok = tok_w[SLOT_COUNT];

  always_comb begin
    for (int k = 0; k < CNT_NUM; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    if (exit_tok.vld) begin
      unique case (exit_tok.status) inside
        ST_ACCEPTED: begin
          cnt_nxt[CNT_RECEIVED] = cnt_r[CNT_RECEIVED] + 32'd1;
          cnt_nxt[CNT_LOST]     = cnt_r[CNT_LOST] + exit_tok.gap;
        end
        ST_INVALID_SIZE, ST_DECODE, ST_BAD_SLOT: begin
          cnt_nxt[CNT_INVALID]  = cnt_r[CNT_INVALID] + 32'd1;
          cnt_nxt[CNT_PROTOCOL] = cnt_r[CNT_PROTOCOL] + 32'd1;
        end
        ST_CRC: begin
          cnt_nxt[CNT_INVALID] = cnt_r[CNT_INVALID] + 32'd1;
          cnt_nxt[CNT_CRC]     = cnt_r[CNT_CRC] + 32'd1;
        end
        ST_FOREIGN: cnt_nxt[CNT_FOREIGN] = cnt_r[CNT_FOREIGN] + 32'd1;
        ST_OUT_OF_ORDER: cnt_nxt[CNT_OOO] = cnt_r[CNT_OOO] + 32'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    pend_v_nxt = pend_v_r;
    out_v_nxt  = out_v_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (out_load) begin
      busy_nxt = 1'b0;
    end
    if (exit_tok.vld) begin
      pend_v_nxt = 1'b1;
    end else if (out_load) begin
      pend_v_nxt = 1'b0;
    end
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RESET;
      busy_r     <= 1'b0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      for (int k = 0; k < CNT_NUM; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      busy_r     <= busy_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
      for (int k = 0; k < CNT_NUM; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.vld <= 1'b0;
    end else begin
      tok0_r.vld <= tok0_nxt.vld;
    end
    if (in_acc) begin
      tok0_r.pkt    <= tok0_nxt.pkt;
      tok0_r.tick   <= tok0_nxt.tick;
      tok0_r.slot   <= tok0_nxt.slot;
      tok0_r.now    <= tok0_nxt.now;
      tok0_r.ip     <= tok0_nxt.ip;
      tok0_r.port   <= tok0_nxt.port;
      tok0_r.sess   <= tok0_nxt.sess;
      tok0_r.seq    <= tok0_nxt.seq;
      tok0_r.status <= tok0_nxt.status;
      tok0_r.bound  <= tok0_nxt.bound;
      tok0_r.gap    <= tok0_nxt.gap;
      tok0_r.mask   <= tok0_nxt.mask;
    end
    if (exit_tok.vld) begin
      pend_r <= exit_tok;
      for (int k = 0; k < CNT_NUM; k++) begin
        pend_cnt_r[k] <= cnt_nxt[k];
      end
    end
    if (out_load) begin
      out_r <= pend_r;
      for (int k = 0; k < CNT_NUM; k++) begin
        out_cnt_r[k] <= pend_cnt_r[k];
      end
    end
  end

  assign out_valid                = out_v_r;
  assign out_status               = out_r.status;
  assign out_slot_out             = out_r.slot;
  assign out_newly_bound          = out_r.bound;
  assign out_lost_in_gap          = out_r.gap;
  assign out_dropped_mask         = out_r.mask;
  assign out_received_total       = out_cnt_r[CNT_RECEIVED];
  assign out_lost_total           = out_cnt_r[CNT_LOST];
  assign out_invalid_total        = out_cnt_r[CNT_INVALID];
  assign out_crc_error_total      = out_cnt_r[CNT_CRC];
  assign out_protocol_error_total = out_cnt_r[CNT_PROTOCOL];
  assign out_foreign_total        = out_cnt_r[CNT_FOREIGN];
  assign out_out_of_order_total   = out_cnt_r[CNT_OOO];

endmodule
`default_nettype wire

// ===== src/csst_cell.sv =====
// One client slot of the tracker chain: holds the slot state and forwards the word.
// Depends on csst_pkg.
`default_nettype none
module csst_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [15:0]          timeout_ms,
  input  wire csst_pkg::csst_tok_t  tok_i,
  output csst_pkg::csst_tok_t       tok_o
);
  import csst_pkg::*;

  localparam logic [MASK_W-1:0] MASK_BIT = (INDEX < MASK_W) ? MASK_W'(1 << INDEX) : '0;

  logic        conn_r, conn_nxt;
  logic        has_seq_r, has_seq_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] sess_r, sess_nxt;
  logic [31:0] last_seq_r, last_seq_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  csst_tok_t   tok_r, tok_nxt;

  logic        hit;
  logic        has_eff;
  logic [31:0] delta;
  logic [31:0] gap_w;
  logic [31:0] age;

  assign hit   = tok_i.vld && tok_i.pkt && (tok_i.slot == 8'(INDEX));
  assign delta = tok_i.seq - last_seq_r;
  assign gap_w = tok_i.seq + ~last_seq_r;
  assign age   = tok_i.now - last_time_r;
  assign has_eff = conn_r && (tok_i.sess == sess_r) && has_seq_r;

  always_comb begin
    conn_nxt      = conn_r;
    has_seq_nxt   = has_seq_r;
    ip_nxt        = ip_r;
    port_nxt      = port_r;
    sess_nxt      = sess_r;
    last_seq_nxt  = last_seq_r;
    last_time_nxt = last_time_r;
    tok_nxt       = tok_i;
    if (hit) begin
      if (conn_r && ((tok_i.ip != ip_r) || (tok_i.port != port_r))) begin
        tok_nxt.status = ST_FOREIGN;
      end else begin
        if (!conn_r) begin
          conn_nxt      = 1'b1;
          ip_nxt        = tok_i.ip;
          port_nxt      = tok_i.port;
          last_time_nxt = tok_i.now;
          tok_nxt.bound = 1'b1;
        end
        sess_nxt    = tok_i.sess;
        has_seq_nxt = has_eff;
        if (has_eff && ((delta == '0) || (delta >= SEQ_HALF))) begin
          tok_nxt.status = ST_OUT_OF_ORDER;
        end else begin
          if (has_eff && (delta != 32'd1)) begin
            tok_nxt.gap = gap_w;
          end
          last_seq_nxt   = tok_i.seq;
          has_seq_nxt    = 1'b1;
          last_time_nxt  = tok_i.now;
          tok_nxt.status = ST_ACCEPTED;
        end
      end
    end else if (tok_i.vld && tok_i.tick && conn_r && (age >= {16'd0, timeout_ms})) begin
      conn_nxt     = 1'b0;
      has_seq_nxt  = 1'b0;
      tok_nxt.mask = tok_i.mask | MASK_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r    <= 1'b0;
      has_seq_r <= 1'b0;
    end else begin
      conn_r    <= conn_nxt;
      has_seq_r <= has_seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    ip_r        <= ip_nxt;
    port_r      <= port_nxt;
    sess_r      <= sess_nxt;
    last_seq_r  <= last_seq_nxt;
    last_time_r <= last_time_nxt;
    tok_r.pkt    <= tok_nxt.pkt;
    tok_r.tick   <= tok_nxt.tick;
    tok_r.slot   <= tok_nxt.slot;
    tok_r.now    <= tok_nxt.now;
    tok_r.ip     <= tok_nxt.ip;
    tok_r.port   <= tok_nxt.port;
    tok_r.sess   <= tok_nxt.sess;
    tok_r.seq    <= tok_nxt.seq;
    tok_r.status <= tok_nxt.status;
    tok_r.bound  <= tok_nxt.bound;
    tok_r.gap    <= tok_nxt.gap;
    tok_r.mask   <= tok_nxt.mask;
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

// ===== src/csst_chk.sv =====
// Port-level checker for the client session sequence tracker and its bind.
// Depends on csst_pkg and client_session_sequence_tracker.
`default_nettype none
module csst_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [7:0]  out_slot_out,
  input wire logic        out_newly_bound,
  input wire logic [31:0] out_lost_in_gap,
  input wire logic [3:0]  out_dropped_mask
);
  import csst_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_lost_in_gap))
    else $error("stalled result word changed");

  a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_TICK) |->
      (out_slot_out == 8'd0) && !out_newly_bound && (out_lost_in_gap == '0))
    else $error("tick result carries packet fields");

  a_packet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_TICK) |->
      (out_dropped_mask == '0) && ((out_status == ST_ACCEPTED) || (out_lost_in_gap == '0)))
    else $error("packet result carries tick mask or stray gap");

endmodule

bind client_session_sequence_tracker csst_chk u_csst_chk (.*);
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for client_session_sequence_tracker: directed and random
// packet and tick words, predicted slot by slot and checked against every result word.
// Depends on csst_pkg and the tracker RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import csst_pkg::*;

  localparam int SLOTS = 4;

  typedef struct packed {
    logic        mode;
    logic [31:0] now;
    logic [1:0]  dstat;
    logic [7:0]  slot;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] sess;
    logic [31:0] seq;
  } word_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        slot;
    logic              bound;
    logic [31:0]       gap;
    logic [MASK_W-1:0] mask;
    logic [31:0]       received;
    logic [31:0]       lost;
    logic [31:0]       invalid;
    logic [31:0]       crc;
    logic [31:0]       protocol;
    logic [31:0]       foreign;
    logic [31:0]       ooo;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic [1:0]  in_decode_status = '0;
  logic [7:0]  in_slot_index = '0;
  logic [31:0] in_source_ip = '0;
  logic [15:0] in_source_port = '0;
  logic [31:0] in_session_id = '0;
  logic [31:0] in_sequence_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_slot_out;
  logic        out_newly_bound;
  logic [31:0] out_lost_in_gap;
  logic [3:0]  out_dropped_mask;
  logic [31:0] out_received_total;
  logic [31:0] out_lost_total;
  logic [31:0] out_invalid_total;
  logic [31:0] out_crc_error_total;
  logic [31:0] out_protocol_error_total;
  logic [31:0] out_foreign_total;
  logic [31:0] out_out_of_order_total;

  client_session_sequence_tracker #(.SLOT_COUNT(SLOTS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_now_ms(in_now_ms),
    .in_decode_status(in_decode_status),
    .in_slot_index(in_slot_index),
    .in_source_ip(in_source_ip),
    .in_source_port(in_source_port),
    .in_session_id(in_session_id),
    .in_sequence_req(in_sequence_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_slot_out(out_slot_out),
    .out_newly_bound(out_newly_bound),
    .out_lost_in_gap(out_lost_in_gap),
    .out_dropped_mask(out_dropped_mask),
    .out_received_total(out_received_total),
    .out_lost_total(out_lost_total),
    .out_invalid_total(out_invalid_total),
    .out_crc_error_total(out_crc_error_total),
    .out_protocol_error_total(out_protocol_error_total),
    .out_foreign_total(out_foreign_total),
    .out_out_of_order_total(out_out_of_order_total)
  );

  always #5 clk = ~clk;

  // Slot table and counters as the tracker should hold them.
  logic        m_conn [SLOTS];
  logic        m_has_seq [SLOTS];
  logic [31:0] m_ip [SLOTS];
  logic [15:0] m_port [SLOTS];
  logic [31:0] m_sess [SLOTS];
  logic [31:0] m_last_seq [SLOTS];
  logic [31:0] m_last_time [SLOTS];
  logic [31:0] m_cnt [CNT_NUM];
  logic [15:0] m_timeout;

  // Source and sequence state of the simulated clients, one per slot.
  logic [31:0] g_ip [SLOTS];
  logic [15:0] g_port [SLOTS];
  logic [31:0] g_sess [SLOTS];
  logic [31:0] g_seq [SLOTS];
  logic [31:0] g_now;

  word_t   word_q [$];
  report_t report_q [$];
  word_t   cur;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_dropped = 0;
  int n_settings = 1;

  function automatic report_t track_word(input word_t w);
    report_t     r;
    logic [31:0] delta;
    logic        ok;
    int          s;
    r = '0;
    if (w.mode) begin
      r.status = ST_TICK;
      for (s = 0; s < SLOTS; s++) begin
        if (m_conn[s] && (w.now - m_last_time[s]) >= {16'd0, m_timeout}) begin
          m_conn[s] = 1'b0;
          m_has_seq[s] = 1'b0;
          m_ip[s] = '0;
          m_port[s] = '0;
          m_sess[s] = '0;
          m_last_seq[s] = '0;
          m_last_time[s] = '0;
          n_dropped++;
          if (s < MASK_W) r.mask[s[1:0]] = 1'b1;
        end
      end
    end else begin
      r.slot = w.slot;
      s = int'(w.slot);
      if (w.dstat != DS_OK) begin
        m_cnt[CNT_INVALID]++;
        if (w.dstat == DS_CRC) begin
          m_cnt[CNT_CRC]++;
          r.status = ST_CRC;
        end else begin
          m_cnt[CNT_PROTOCOL]++;
          if (w.dstat == DS_SIZE) r.status = ST_INVALID_SIZE;
          else r.status = ST_DECODE;
        end
      end else if (s >= SLOTS) begin
        m_cnt[CNT_INVALID]++;
        m_cnt[CNT_PROTOCOL]++;
        r.status = ST_BAD_SLOT;
      end else if (m_conn[s] && (m_ip[s] != w.ip || m_port[s] != w.port)) begin
        m_cnt[CNT_FOREIGN]++;
        r.status = ST_FOREIGN;
      end else begin
        ok = 1'b1;
        if (!m_conn[s]) begin
          m_conn[s] = 1'b1;
          m_ip[s] = w.ip;
          m_port[s] = w.port;
          m_sess[s] = w.sess;
          m_has_seq[s] = 1'b0;
          m_last_time[s] = w.now;
          r.bound = 1'b1;
        end else if (w.sess != m_sess[s]) begin
          m_sess[s] = w.sess;
          m_has_seq[s] = 1'b0;
        end
        if (m_has_seq[s]) begin
          delta = w.seq - m_last_seq[s];
          if (delta == 0 || delta >= SEQ_HALF) begin
            m_cnt[CNT_OOO]++;
            r.status = ST_OUT_OF_ORDER;
            ok = 1'b0;
          end else if (delta > 1) begin
            r.gap = delta - 32'd1;
            m_cnt[CNT_LOST] += r.gap;
          end
        end
        if (ok) begin
          m_last_seq[s] = w.seq;
          m_has_seq[s] = 1'b1;
          m_last_time[s] = w.now;
          m_cnt[CNT_RECEIVED]++;
          r.status = ST_ACCEPTED;
        end
      end
    end
    r.received = m_cnt[CNT_RECEIVED];
    r.lost = m_cnt[CNT_LOST];
    r.invalid = m_cnt[CNT_INVALID];
    r.crc = m_cnt[CNT_CRC];
    r.protocol = m_cnt[CNT_PROTOCOL];
    r.foreign = m_cnt[CNT_FOREIGN];
    r.ooo = m_cnt[CNT_OOO];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("result word %0d: %s expected %h, got %h", n_checked, name, exp_v, act_v);
    end
  endtask

  // Driver: presents queued words, with random idle bursts between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        report_q.push_back(track_word(cur));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (word_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < in_idle_pct) begin
          gap_left <= $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          cur = word_q.pop_front();
          in_mode <= cur.mode;
          in_now_ms <= cur.now;
          in_decode_status <= cur.dstat;
          in_slot_index <= cur.slot;
          in_source_ip <= cur.ip;
          in_source_port <= cur.port;
          in_session_id <= cur.sess;
          in_sequence_req <= cur.seq;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // One long hold of the result channel so that the pipeline backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= 200) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    report_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result word with no prediction pending: status %0d slot %0d",
                     out_status, out_slot_out);
        end else begin
          e = report_q.pop_front();
          check_field("status", 32'(e.status), 32'(out_status));
          check_field("slot_out", 32'(e.slot), 32'(out_slot_out));
          check_field("newly_bound", 32'(e.bound), 32'(out_newly_bound));
          check_field("lost_in_gap", e.gap, out_lost_in_gap);
          check_field("dropped_mask", 32'(e.mask), 32'(out_dropped_mask));
          check_field("received_total", e.received, out_received_total);
          check_field("lost_total", e.lost, out_lost_total);
          check_field("invalid_total", e.invalid, out_invalid_total);
          check_field("crc_error_total", e.crc, out_crc_error_total);
          check_field("protocol_error_total", e.protocol, out_protocol_error_total);
          check_field("foreign_total", e.foreign, out_foreign_total);
          check_field("out_of_order_total", e.ooo, out_out_of_order_total);
        end
        n_checked++;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        stall_left <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_word(input logic mode, input logic [31:0] now, input logic [1:0] dstat,
                          input logic [7:0] slot, input logic [31:0] ip,
                          input logic [15:0] port, input logic [31:0] sess,
                          input logic [31:0] seq);
    word_t w;
    w = '{mode, now, dstat, slot, ip, port, sess, seq};
    word_q.push_back(w);
  endtask

  task automatic add_traffic(input int count, input int unsigned tmax);
    word_t w;
    int    r;
    int    s;
    repeat (count) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 99) == 0) g_now = $urandom;
      else g_now = g_now + $urandom_range(0, tmax);
      w = '{1'b0, g_now, DS_OK, 8'(s), g_ip[s], g_port[s], g_sess[s], g_seq[s] + 1};
      if (r < 6) begin
        w = '{1'b1, g_now, 2'($urandom), 8'($urandom), $urandom, 16'($urandom),
              $urandom, $urandom};
      end else if (r < 10) begin
        w = '{1'b0, g_now, 2'($urandom), 8'($urandom), $urandom, 16'($urandom),
              $urandom, $urandom};
      end else if (r < 14) begin
        w.dstat = 2'($urandom_range(1, 3));
        w.slot = 8'($urandom);
      end else if (r < 17) begin
        w.slot = 8'($urandom_range(SLOTS, 255));
      end else if (r < 21) begin
        if ($urandom_range(0, 1) == 0) w.ip = $urandom;
        else w.port = w.port ^ (16'd1 << $urandom_range(0, 15));
      end else if (r < 23) begin
        g_ip[s] = $urandom;
        g_port[s] = 16'($urandom);
        g_sess[s] = $urandom;
        g_seq[s] = $urandom;
        w = '{1'b0, g_now, DS_OK, 8'(s), g_ip[s], g_port[s], g_sess[s], g_seq[s]};
      end else if (r < 27) begin
        g_sess[s] = $urandom;
        g_seq[s] = $urandom;
        w.sess = g_sess[s];
        w.seq = g_seq[s];
      end else if (r < 31) begin
        w.seq = g_seq[s];
      end else if (r < 34) begin
        if ($urandom_range(0, 1) == 0) w.seq = g_seq[s] - $urandom_range(1, 50);
        else w.seq = g_seq[s] + SEQ_HALF + $urandom_range(0, 1000);
      end else if (r < 38) begin
        w.seq = g_seq[s] + $urandom_range(2, 20);
        g_seq[s] = w.seq;
      end else if (r < 40) begin
        w.seq = g_seq[s] + $urandom_range(2, 32'h7FFF_FFFF);
        g_seq[s] = w.seq;
      end else begin
        g_seq[s] = w.seq;
      end
      word_q.push_back(w);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || report_q.size() != 0);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    m_timeout = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [31:0] t0;
    int          i;
    logic [15:0] v;
    m_timeout = TIMEOUT_RESET;
    for (i = 0; i < SLOTS; i++) begin
      m_conn[i] = 1'b0;
      m_has_seq[i] = 1'b0;
      m_ip[i] = '0;
      m_port[i] = '0;
      m_sess[i] = '0;
      m_last_seq[i] = '0;
      m_last_time[i] = '0;
      g_ip[i] = $urandom;
      g_port[i] = 16'($urandom);
      g_sess[i] = $urandom;
      g_seq[i] = $urandom;
    end
    for (i = 0; i < CNT_NUM; i++) m_cnt[i] = '0;
    t0 = 32'hFFFF_FE00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 20;
    out_stall_pct = 20;
    add_word(1'b1, t0, DS_SIZE, 8'hFF, '1, '1, '1, '1);
    add_word(1'b0, t0, DS_CRC, 8'hFF, '1, '1, '1, '1);
    add_word(1'b0, t0, DS_DECODE, 8'h00, '0, '0, '0, '0);
    add_word(1'b0, t0, DS_SIZE, 8'h01, '1, '0, '1, '0);
    add_word(1'b0, t0, DS_OK, 8'hFF, '0, '0, '0, '0);
    add_word(1'b0, t0, DS_OK, 8'(SLOTS), '0, '0, '0, '0);
    add_word(1'b0, t0, DS_OK, 8'd0, '0, '0, '0, 32'hFFFF_FFFF);
    add_word(1'b0, t0, DS_OK, 8'd0, '0, '0, '0, 32'h0000_0000);
    add_word(1'b0, t0, DS_OK, 8'd0, '0, '0, '0, 32'h0000_0000);
    add_word(1'b0, t0, DS_OK, 8'd0, '0, '0, '0, 32'h8000_0000);
    add_word(1'b0, t0, DS_OK, 8'd0, '0, '0, '0, 32'h7FFF_FFFF);
    add_word(1'b0, t0, DS_OK, 8'd0, 32'd1, '0, '0, 32'h8000_0000);
    add_word(1'b0, t0, DS_OK, 8'd0, '0, 16'h8000, '0, 32'h8000_0000);
    add_word(1'b0, t0, DS_OK, 8'd0, '0, '0, '1, 32'd3);
    add_word(1'b0, t0, DS_OK, 8'd0, '0, '0, '1, 32'd3);
    add_word(1'b0, t0, DS_OK, 8'd1, '1, '1, 32'h1234_5678, 32'h0000_0000);
    add_word(1'b0, t0, DS_OK, 8'd1, '1, '1, 32'h1234_5678, 32'h7FFF_FFFF);
    add_word(1'b0, t0, DS_OK, 8'd1, '1, '1, 32'h1234_5678, 32'hFFFF_FFFE);
    add_word(1'b0, t0, DS_OK, 8'd1, '1, '1, 32'h1234_5678, 32'h7FFF_FFFD);
    add_word(1'b0, t0 + 500, DS_OK, 8'd3, 32'hA5A5_A5A5, 16'h5A5A, 32'd7, 32'd9);
    add_word(1'b1, t0 + 999, DS_OK, 8'd0, '0, '0, '0, '0);
    add_word(1'b1, t0 + 1000, DS_OK, 8'd0, '0, '0, '0, '0);
    add_word(1'b1, t0 + 1500, DS_OK, 8'd0, '0, '0, '0, '0);
    add_word(1'b0, t0 + 1500, DS_OK, 8'd0, g_ip[0], g_port[0], g_sess[0], g_seq[0]);
    g_now = t0 + 1500;
    wait_idle();

    write_timeout(16'hFFFF);
    in_idle_pct = 30;
    out_stall_pct = 30;
    add_traffic(400, 4000);
    wait_idle();

    write_timeout(16'd1);
    in_idle_pct = 0;
    out_stall_pct = 0;
    add_traffic(300, 2);
    wait_idle();

    write_timeout(16'd0);
    in_idle_pct = 50;
    out_stall_pct = 50;
    add_traffic(150, 3);
    wait_idle();

    repeat (4) begin
      v = 16'($urandom_range(2, 5000));
      write_timeout(v);
      in_idle_pct = 15;
      out_stall_pct = 40;
      add_traffic(100, v / 8 + 1);
      wait_idle();
    end

    write_timeout(16'd300);
    in_idle_pct = 0;
    out_stall_pct = 0;
    add_traffic(400, 40);
    wait_idle();
    repeat (SLOTS + 4) @(posedge clk);

    $display("Checked %0d result words over %0d timeout settings; %0d slots timed out.",
             n_checked, n_settings, n_dropped);
    $display("Mismatches found: %0d.", n_mismatch);
    if (n_mismatch == 0 && report_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run did not drain in time.");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
